// File: hdl/frame_playback_sequencer_assert.svh
// Assertion macros shared by the frame playback sequencer checkers.
`ifndef FRAME_PLAYBACK_SEQUENCER_ASSERT_SVH
`define FRAME_PLAYBACK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame sequencer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame sequencer check failed");

`endif

// File: hdl/fps_pkg.sv
// Shared types, codes and helper functions of the frame playback sequencer.
`timescale 1ns / 1ps
package fps_pkg;

  localparam int FRAME_BITS = 16;
  localparam int LIST_DEPTH = 16;
  localparam int LIST_AW    = 4;
  localparam int ONE_FRAME  = 65536;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  localparam int PHASE_W    = 21;

  typedef logic [FRAME_BITS-1:0] frame_t;

  // Command codes carried in the input tuser.
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_PAUSE  = 3'd2;
  localparam logic [2:0] CMD_RESUME = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;
  localparam logic [2:0] CMD_WRITE  = 3'd5;

  // Play modes.
  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_LOOP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;
  localparam logic [1:0] MODE_LIST     = 2'd3;

  // Run states.
  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_PLAYING = 2'd1;
  localparam logic [1:0] RUN_PAUSED  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PLAY_MODE   = 3'd0;
  localparam logic [2:0] REG_FIRST_FRAME = 3'd1;
  localparam logic [2:0] REG_LAST_FRAME  = 3'd2;
  localparam logic [2:0] REG_SPEED       = 3'd3;
  localparam logic [2:0] REG_LIST_LENGTH = 3'd4;

  typedef struct packed {
    frame_t             run_first;
    frame_t             run_last;
    frame_t             shown;
    frame_t             upcoming;
    logic [LIST_AW-1:0] list_pos;
    logic [1:0]         run_state;
  } frame_st_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_add;
    logic do_cmd;
    logic do_step;
    logic cap;
  } fps_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic tick_go;
    logic out_free;
    logic step_last;
  } fps_stat_t;

  // One frame step: up when direction and order agree, down otherwise.
  function automatic frame_t step_frame(input logic fwd, input logic chrono, input frame_t f);
    if (fwd == chrono) begin
      return f + 1'b1;
    end
    return f - 1'b1;
  endfunction

  // True when the shown frame has reached the end of the run in this direction.
  function automatic logic end_hit(input logic fwd, input frame_t first, input frame_t last,
                                   input frame_t shown);
    logic chrono;
    chrono = (first <= last);
    if (fwd) begin
      return chrono ? (shown >= last) : (shown <= last);
    end
    return chrono ? (shown <= first) : (shown >= first);
  endfunction

endpackage

// File: hdl/frame_playback_sequencer.sv
// Top level of the frame playback sequencer: controller plus datapath.
//
//   channel  | direction | handshake                    | contents
//   ---------+-----------+------------------------------+--------------------------------
//   config   | in        | cfg_we_i                     | register index, write data
//   s_axis   | in        | s_axis_tvalid, s_axis_tready | command in tuser, operands in tdata
//   m_axis   | out       | m_axis_tvalid, m_axis_tready | frames, phase, state; tlast ends item
//
// A non-tick command is captured and then applied in a single update that writes
// its result. A tick that advances is captured, multiplied and added to the phase,
// and then makes each frame crossing in turn through the shared frame-advance logic.
// Reset is asynchronous and active low; it stops playback and clears the phase.
// A stalled output holds the crossing loop; the input is taken again once the
// current transaction has delivered its last result to the output register.
`timescale 1ns / 1ps
module frame_playback_sequencer #(
  parameter int MAX_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  // Command stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: delta_time[15:0], entry_index[19:16], entry_value[35:20], zero pad
  input  logic [fps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]                        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: current_frame[15:0], upcoming_frame[31:16], phase[52:32],
  //        play_state[54:53], zero pad
  output logic [fps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import fps_pkg::*;

  fps_cmd_t  cmd;
  fps_stat_t stat;

  // The controller sequences each transaction: capture, then either a single
  // command update or the multiply, phase add and crossing loop of a tick.
  fps_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The datapath holds configuration, playback state, the frame list and the
  // output register that decouples results from the downstream ready.
  fps_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_user_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

// File: hdl/fps_ctrl.sv
// Controller state machine of the frame playback sequencer.
`timescale 1ns / 1ps
module fps_ctrl #(
  parameter int MAX_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  fps_pkg::fps_stat_t stat_i,
  output fps_pkg::fps_cmd_t  cmd_o
);
  import fps_pkg::*;

  localparam int CW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_STEP = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] n_q, n_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    cmd_o   = '0;
    cmd_o.cap = (n_q == CW'(MAX_STEPS - 1));
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.tick_go) begin
          cmd_o.do_mul = 1'b1;
          state_d      = S_ADD;
        end else if (stat_i.out_free) begin
          cmd_o.do_cmd = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ADD: begin
        cmd_o.do_add = 1'b1;
        n_d          = '0;
        state_d      = S_STEP;
      end
      S_STEP: begin
        if (stat_i.out_free) begin
          cmd_o.do_step = 1'b1;
          if (stat_i.step_last) begin
            state_d = S_IDLE;
          end else begin
            n_d = n_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

endmodule

// File: hdl/fps_datapath.sv
// Datapath of the frame playback sequencer: registers, frame list, phase and output stage.
`timescale 1ns / 1ps
module fps_datapath #(
  parameter int MAX_STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fps_pkg::fps_cmd_t                   cmd_i,
  output fps_pkg::fps_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [15:0]                         cfg_wdata_i,
  input  logic [2:0]                          s_user_i,
  input  logic [fps_pkg::IN_DATA_W-1:0]       s_data_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [fps_pkg::OUT_DATA_W-1:0]      m_data_o,
  output logic                                m_last_o
);
  import fps_pkg::*;

  localparam int PH_RAW = $clog2(MAX_STEPS + 1) + 18;
  localparam int PH_W   = (PH_RAW > PHASE_W) ? PH_RAW : PHASE_W;

  localparam logic signed [32:0]     LIM      = 33'(MAX_STEPS) <<< 16;
  localparam logic signed [32:0]     NLIM     = -LIM;
  localparam logic signed [PH_W-1:0] PH_ZERO  = '0;
  localparam logic signed [PH_W-1:0] PH_ONE   = PH_W'(ONE_FRAME);
  localparam logic signed [PH_W-1:0] PH_FSAT  = PH_W'(ONE_FRAME - 1);
  localparam logic signed [PH_W-1:0] PH_BSAT  = PH_W'(1);

  // Configuration registers.
  logic [1:0]         mode_q;
  frame_t             first_q, last_q;
  logic signed [15:0] speed_q;
  logic [4:0]         llen_q;

  // Latched input transaction.
  logic [2:0]         op_q;
  logic [15:0]        dt_q;
  logic [LIST_AW-1:0] eidx_q;
  frame_t             evalue_q;

  // Tick arithmetic.
  logic signed [32:0]     prod_q, prod_c;
  logic signed [PH_W-1:0] ph_q, ph_n, ph_fin;

  // Playback state.
  frame_st_t              st_q, st_d, a_in, a_out;
  logic signed [PH_W-1:0] phase_q, phase_d;
  frame_t                 list_q [LIST_DEPTH];

  // Output stage.
  logic                 ov_q;
  frame_t               o_cur_q, o_up_q;
  logic [PHASE_W-1:0]   o_ph_q;
  logic [1:0]           o_st_q;
  logic                 o_last_q, o_last_d;

  logic fwd, crossed, more, a_live, wr_en, out_free;

  assign fwd      = !speed_q[15];
  assign out_free = !ov_q || m_ready_i;

  // Configuration writes; indexes beyond the registers are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ONESHOT;
      first_q <= '0;
      last_q  <= '0;
      speed_q <= 16'sd16;
      llen_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PLAY_MODE:   mode_q  <= cfg_wdata_i[1:0];
        REG_FIRST_FRAME: first_q <= cfg_wdata_i;
        REG_LAST_FRAME:  last_q  <= cfg_wdata_i;
        REG_SPEED:       speed_q <= $signed(cfg_wdata_i);
        REG_LIST_LENGTH: llen_q  <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Input fields, the product and the summed phase are payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= s_user_i;
      dt_q     <= s_data_i[15:0];
      eidx_q   <= s_data_i[19:16];
      evalue_q <= s_data_i[35:20];
    end
    if (cmd_i.do_mul) begin
      prod_q <= $signed({1'b0, dt_q}) * speed_q;
    end
    // Each crossing hands its remaining phase on to the next one.
    if (cmd_i.do_add) begin
      ph_q <= phase_q + $signed(prod_c[PH_W-1:0]);
    end else if (cmd_i.do_step) begin
      ph_q <= ph_fin;
    end
  end

  always_comb begin
    if (prod_q > LIM) begin
      prod_c = LIM;
    end else if (prod_q < NLIM) begin
      prod_c = NLIM;
    end else begin
      prod_c = prod_q;
    end
  end

  // Frame advance by play mode, shared by play and by each crossing.
  always_comb begin
    logic               chrono, chrono2, endr;
    logic [4:0]         cnt, pos5, tmp;
    logic [LIST_AW-1:0] npos;
    frame_t             lv;

    if (cmd_i.do_cmd) begin
      a_in           = st_q;
      a_in.run_first = first_q;
      a_in.run_last  = last_q;
      a_in.shown     = first_q;
      a_in.list_pos  = '0;
      a_in.run_state = RUN_PLAYING;
    end else begin
      a_in = st_q;
      if (fwd) begin
        a_in.shown = st_q.upcoming;
      end else begin
        a_in.upcoming = st_q.shown;
      end
    end

    a_out   = a_in;
    a_live  = 1'b1;
    chrono  = (a_in.run_first <= a_in.run_last);
    chrono2 = chrono;
    endr    = end_hit(fwd, a_in.run_first, a_in.run_last, a_in.shown);
    cnt     = (llen_q > 5'(LIST_DEPTH)) ? 5'(LIST_DEPTH) : llen_q;
    pos5    = {1'b0, a_in.list_pos};
    tmp     = cnt - 5'd1;
    if (fwd) begin
      npos = (pos5 >= cnt - 5'd1) ? '0 : a_in.list_pos + 1'b1;
    end else begin
      npos = (a_in.list_pos == '0) ? tmp[LIST_AW-1:0] : a_in.list_pos - 1'b1;
    end
    lv = list_q[npos];

    unique case (mode_q)
      MODE_ONESHOT: begin
        if (endr) begin
          a_out.run_state = RUN_STOPPED;
          a_out.list_pos  = '0;
          a_live          = 1'b0;
        end else if (fwd) begin
          a_out.upcoming = step_frame(fwd, chrono, a_in.shown);
        end else begin
          a_out.shown = step_frame(fwd, chrono, a_in.shown);
        end
      end
      MODE_LOOP: begin
        if (endr) begin
          if (fwd) begin
            a_out.upcoming = a_in.run_first;
          end else begin
            a_out.shown = a_in.run_last;
          end
        end else if (fwd) begin
          a_out.upcoming = step_frame(fwd, chrono, a_in.shown);
        end else begin
          a_out.shown = step_frame(fwd, chrono, a_in.shown);
        end
      end
      MODE_PINGPONG: begin
        if (endr) begin
          a_out.run_first = a_in.run_last;
          a_out.run_last  = a_in.run_first;
          chrono2         = (a_in.run_last <= a_in.run_first);
        end
        if (fwd) begin
          a_out.upcoming = step_frame(fwd, chrono2, a_in.shown);
        end else begin
          a_out.shown = step_frame(fwd, chrono2, a_in.shown);
        end
      end
      MODE_LIST: begin
        // Fewer than two entries in the list leaves the frames as they are.
        if (cnt >= 5'd2) begin
          a_out.list_pos = npos;
          if (fwd) begin
            a_out.upcoming = lv;
          end else begin
            a_out.shown = lv;
          end
        end
      end
      default: ;
    endcase
  end

  // One whole-frame crossing of the tick phase.
  always_comb begin
    crossed = fwd ? (ph_q >= PH_ONE) : (ph_q <= PH_ZERO);
    ph_n    = fwd ? (ph_q - PH_ONE) : (ph_q + PH_ONE);
    more    = a_live && (fwd ? (ph_n >= PH_ONE) : (ph_n <= PH_ZERO));
    if (!crossed) begin
      ph_fin = ph_q;
    end else if (more && cmd_i.cap) begin
      ph_fin = fwd ? PH_FSAT : PH_BSAT;
    end else begin
      ph_fin = ph_n;
    end
  end

  assign stat_o.tick_go   = (op_q == CMD_TICK) && (st_q.run_state == RUN_PLAYING) &&
                            (dt_q != '0);
  assign stat_o.out_free  = out_free;
  assign stat_o.step_last = !crossed || !more || cmd_i.cap;

  // Next playback state and the result it shows.
  always_comb begin
    st_d     = st_q;
    phase_d  = phase_q;
    wr_en    = 1'b0;
    o_last_d = 1'b1;
    if (cmd_i.do_cmd) begin
      unique case (op_q)
        CMD_PLAY: begin
          st_d    = a_out;
          phase_d = PH_ZERO;
        end
        CMD_PAUSE: begin
          if (st_q.run_state == RUN_PLAYING) begin
            st_d.run_state = RUN_PAUSED;
          end
        end
        CMD_RESUME: begin
          if (st_q.run_state == RUN_PAUSED) begin
            st_d.run_state = RUN_PLAYING;
          end
        end
        CMD_STOP: begin
          st_d.run_state = RUN_STOPPED;
          st_d.list_pos  = '0;
        end
        CMD_WRITE: wr_en = 1'b1;
        default: ;
      endcase
    end else if (cmd_i.do_step) begin
      if (crossed) begin
        st_d = a_out;
      end
      phase_d  = ph_fin;
      o_last_d = !crossed || !more || cmd_i.cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      phase_q <= PH_ZERO;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      if (cmd_i.do_cmd || cmd_i.do_step) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Every slot index is inside the list, so writes are always taken.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      list_q[eidx_q] <= evalue_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_cmd || cmd_i.do_step) begin
      o_cur_q  <= st_d.shown;
      o_up_q   <= st_d.upcoming;
      o_ph_q   <= phase_d[PHASE_W-1:0];
      o_st_q   <= st_d.run_state;
      o_last_q <= o_last_d;
    end
  end

  assign m_valid_o = ov_q;
  assign m_last_o  = o_last_q;
  assign m_data_o  = {1'b0, o_st_q, o_ph_q, o_up_q, o_cur_q};

endmodule

// File: hdl/fps_checker.sv
// Port-level assertion checker of the frame playback sequencer and its bind.
`timescale 1ns / 1ps
`include "frame_playback_sequencer_assert.svh"
module fps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import fps_pkg::*;

  // A stalled result keeps its payload.
  `FPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Only one command is in flight: the input closes right after a transaction.
  `FPS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A result that is not the last of its tick is shown while still playing.
  `FPS_ASSERT_NOW(a_mid_playing, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[54:53] == RUN_PLAYING)

  // Crossings follow one another without a gap once a middle result is taken.
  `FPS_ASSERT_NEXT(a_mid_follow, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

bind frame_playback_sequencer fps_checker u_fps_checker (.*);
